@@ hw/rtl/c2d_pkg.sv @@
// Shared constants, types and register codes of the 5x5 convolution stream unit.
package c2d_pkg;

  // Pixel and kernel geometry
  localparam int unsigned PixW        = 8;
  localparam int unsigned KernelSize  = 5;
  localparam int unsigned NumTaps     = KernelSize * KernelSize;
  localparam int unsigned LineRows    = KernelSize - 1;
  localparam int unsigned LaneW       = $clog2(LineRows);
  localparam int unsigned MaxWidthDef = 256;

  // Configuration port
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned DimW     = 9;
  localparam int unsigned CoefW    = 8;
  localparam logic [DimW-1:0] DimReset = 9'd256;

  // Arithmetic widths: pixel times coefficient, row of five, five rows
  localparam int unsigned ProdW = 16;
  localparam int unsigned RowW  = ProdW + $clog2(KernelSize);
  localparam int unsigned SumW  = RowW + $clog2(KernelSize);
  localparam int unsigned PixMax = 255;

  typedef enum logic [CfgIdxW-1:0] {
    RegImageWidth  = 3'd0,
    RegImageHeight = 3'd1,
    RegCoefWord0   = 3'd2,
    RegCoefWord1   = 3'd3,
    RegCoefWord2   = 3'd4,
    RegCoefWord3   = 3'd5
  } reg_idx_e;

  // Coefficient k = m*KernelSize+n at entry k
  typedef logic [NumTaps-1:0][CoefW-1:0] coef_vec_t;

  // Window entry [m][n] holds input(i-m, j-n)
  typedef logic [KernelSize-1:0][KernelSize-1:0][PixW-1:0] pix_win_t;

  typedef struct packed {
    logic     frame_last;
    pix_win_t pix;
  } win_t;

endpackage

@@ hw/rtl/c2d_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module c2d_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write, and register the read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/c2d_front.sv @@
// Raster counters, line store read-modify-write and the 5x5 pixel window.
module c2d_front import c2d_pkg::*; #(
  parameter int unsigned MaxWidth = MaxWidthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [DimW-1:0] width_i,
  input  logic [DimW-1:0] height_i,
  input  logic [PixW-1:0] pixel_i,
  input  logic            valid_i,
  output logic            ready_o,
  output logic            win_valid_o,
  output win_t            win_o,
  input  logic            win_ready_i
);

  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned CntW = ((ColW > DimW) ? ColW : DimW) + 1;

  typedef logic [LineRows-1:0][PixW-1:0] word_t;

  // Counters and clearing sweep
  logic [ColW-1:0] col_q, col_d;
  logic [DimW-1:0] row_q, row_d;
  logic            clr_busy_q;
  logic [ColW-1:0] clr_addr_q;

  // Stage 1: pixel waiting for its line store word
  logic            s1_v_q;
  logic [PixW-1:0] s1_px_q;
  logic [ColW-1:0] s1_col_q;
  logic [DimW-1:0] s1_row_q;
  logic            s1_col0_q;
  logic            s1_last_q;

  // Stage 2: window
  logic     s2_v_q;
  logic     s2_last_q;
  pix_win_t win_q, win_d, base;

  // Forwarding of a word written in the cycle it was read
  logic  byp_v_q;
  word_t byp_word_q;

  logic [CntW-1:0] eff_w;
  logic [DimW-1:0] eff_h;
  logic            row_end, frame_end;
  logic            accept, move12, s2_ready;
  word_t           ram_rdata, rword, new_word;
  logic            ram_we;
  logic [ColW-1:0] ram_waddr;
  word_t           ram_wdata;
  logic [LaneW-1:0] lane;

  // Effective image size: zero acts as one, width limited to the store
  always_comb begin
    if (width_i == '0) begin
      eff_w = CntW'(1);
    end else if (CntW'(width_i) > CntW'(MaxWidth)) begin
      eff_w = CntW'(MaxWidth);
    end else begin
      eff_w = CntW'(width_i);
    end
    eff_h = (height_i == '0) ? DimW'(1) : height_i;
  end

  // Handshake
  assign s2_ready = !s2_v_q || win_ready_i;
  assign move12   = s1_v_q && s2_ready;
  assign ready_o  = !clr_busy_q && (!s1_v_q || s2_ready);
  assign accept   = valid_i && ready_o;

  // Next column and row
  always_comb begin
    row_end   = (CntW'(col_q) + CntW'(1)) >= eff_w;
    frame_end = row_end && ((DimW + 1)'(row_q) + (DimW + 1)'(1) >= (DimW + 1)'(eff_h));
    col_d     = col_q;
    row_d     = row_q;
    if (row_end) begin
      col_d = '0;
      row_d = frame_end ? '0 : row_q + DimW'(1);
    end else begin
      col_d = col_q + ColW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
      byp_v_q    <= 1'b0;
    end else begin
      // Sweep the line store to zero after reset
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + ColW'(1);
        if (clr_addr_q == ColW'(MaxWidth - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (accept) begin
        col_q   <= col_d;
        row_q   <= row_d;
        byp_v_q <= move12 && (s1_col_q == col_q);
      end
      if (accept) begin
        s1_v_q <= 1'b1;
      end else if (move12) begin
        s1_v_q <= 1'b0;
      end
      if (move12) begin
        s2_v_q <= 1'b1;
      end else if (win_ready_i) begin
        s2_v_q <= 1'b0;
      end
    end
  end

  // Capture stage 1 payload and the forwarded word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q    <= pixel_i;
      s1_col_q   <= col_q;
      s1_row_q   <= row_q;
      s1_col0_q  <= (col_q == '0);
      s1_last_q  <= frame_end;
      byp_word_q <= new_word;
    end
    if (move12) begin
      s2_last_q <= s1_last_q;
      win_q     <= win_d;
    end
  end

  // Merge the new pixel into its ring lane
  always_comb begin
    rword    = byp_v_q ? byp_word_q : ram_rdata;
    new_word = rword;
    new_word[s1_row_q[LaneW-1:0]] = s1_px_q;
  end

  // Line store write port: clearing sweep or write-back
  always_comb begin
    if (clr_busy_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = move12;
      ram_waddr = s1_col_q;
      ram_wdata = new_word;
    end
  end

  c2d_ram #(
    .Width(LineRows * PixW),
    .Depth(MaxWidth)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (accept),
    .raddr_i(col_q),
    .rdata_o(ram_rdata)
  );

  // Shift the window; clear it at the start of a row, zero taps above the image
  always_comb begin
    lane  = '0;
    base  = s1_col0_q ? '0 : win_q;
    win_d = base;
    for (int m = 0; m < KernelSize; m++) begin
      for (int n = KernelSize - 1; n > 0; n--) begin
        win_d[m][n] = base[m][n-1];
      end
    end
    win_d[0][0] = s1_px_q;
    for (int m = 1; m < KernelSize; m++) begin
      lane = s1_row_q[LaneW-1:0] - LaneW'(m);
      win_d[m][0] = (s1_row_q >= DimW'(m)) ? rword[lane] : '0;
    end
  end

  assign win_valid_o      = s2_v_q;
  assign win_o.frame_last = s2_last_q;
  assign win_o.pix        = win_q;

endmodule

@@ hw/rtl/c2d_mac.sv @@
// Multiply-accumulate pipeline over the 5x5 window with clamp to 0..255.
module c2d_mac import c2d_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            win_valid_i,
  input  win_t            win_i,
  output logic            win_ready_o,
  input  coef_vec_t       coef_i,
  output logic [PixW-1:0] pixel_o,
  output logic            frame_last_o,
  output logic            valid_o,
  input  logic            ready_i
);

  logic                   v3_q, v4_q, v5_q;
  logic                   last3_q, last4_q, last5_q;
  logic                   r3, r4, r5;
  logic signed [ProdW-1:0] prod_q [NumTaps];
  logic signed [ProdW-1:0] prod_d [NumTaps];
  logic signed [RowW-1:0]  rsum_q [KernelSize];
  logic signed [RowW-1:0]  rsum_d [KernelSize];
  logic signed [SumW-1:0]  total;
  logic [PixW-1:0]         pix_d, pix_q;

  // Per-stage ready: a stage moves when the next one is empty or moving
  assign r5          = !v5_q || ready_i;
  assign r4          = !v4_q || r5;
  assign r3          = !v3_q || r4;
  assign win_ready_o = r3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (r3) begin
        v3_q <= win_valid_i;
      end
      if (r4) begin
        v4_q <= v3_q;
      end
      if (r5) begin
        v5_q <= v4_q;
      end
    end
  end

  // Products of every tap, both operands widened to the product width
  always_comb begin
    int k;
    k = 0;
    for (int m = 0; m < KernelSize; m++) begin
      for (int n = 0; n < KernelSize; n++) begin
        k = m * KernelSize + n;
        prod_d[k] = $signed(ProdW'(win_i.pix[m][n])) *
                    $signed({{(ProdW-CoefW){coef_i[k][CoefW-1]}}, coef_i[k]});
      end
    end
  end

  // Row sums
  always_comb begin
    for (int m = 0; m < KernelSize; m++) begin
      rsum_d[m] = '0;
      for (int n = 0; n < KernelSize; n++) begin
        rsum_d[m] = rsum_d[m] + RowW'(prod_q[m * KernelSize + n]);
      end
    end
  end

  // Total and clamp
  always_comb begin
    total = '0;
    for (int m = 0; m < KernelSize; m++) begin
      total = total + SumW'(rsum_q[m]);
    end
    if (total < 0) begin
      pix_d = '0;
    end else if (total > SumW'(PixMax)) begin
      pix_d = PixW'(PixMax);
    end else begin
      pix_d = total[PixW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (r3 && win_valid_i) begin
      prod_q  <= prod_d;
      last3_q <= win_i.frame_last;
    end
    if (r4 && v3_q) begin
      rsum_q  <= rsum_d;
      last4_q <= last3_q;
    end
    if (r5 && v4_q) begin
      pix_q   <= pix_d;
      last5_q <= last4_q;
    end
  end

  assign pixel_o      = pix_q;
  assign frame_last_o = last5_q;
  assign valid_o      = v5_q;

endmodule

@@ hw/rtl/conv2d_5x5_clamp_stream_unit.sv @@
// Top level of the 5x5 convolution stream unit: configuration registers and datapath.
//
// Takes one 8-bit pixel per transfer in raster order and returns one clamped
// convolution result per pixel, in order, with frame_last on the last pixel of
// the image. Sustained rate is one pixel per clock while the output side is
// ready: the line store RAM takes one read and one write-back per cycle, and
// the 25 products are formed in parallel. A pixel's result passes through the
// stage 1, window, product, row-sum and clamped-result registers. After reset
// the line store is swept to zero, one column word per cycle, so input is held
// off until the sweep ends (configuration writes are taken throughout). The user
// must write configuration only while the unit is idle; the unit does not enforce it.
module conv2d_5x5_clamp_stream_unit import c2d_pkg::*; #(
  parameter int unsigned MaxWidth = MaxWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [PixW-1:0]     pixel_in_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic [PixW-1:0]     pixel_out_o,
  output logic                frame_last_o,
  output logic                out_valid_o,
  input  logic                out_ready_i
);

  logic [DimW-1:0] width_q, height_q;
  coef_vec_t       coef_q;
  logic            win_valid, win_ready;
  win_t            win;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimReset;
      height_q <= DimReset;
      coef_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegImageWidth:  width_q       <= cfg_data_i[DimW-1:0];
        RegImageHeight: height_q      <= cfg_data_i[DimW-1:0];
        RegCoefWord0:   coef_q[7:0]   <= cfg_data_i;
        RegCoefWord1:   coef_q[15:8]  <= cfg_data_i;
        RegCoefWord2:   coef_q[23:16] <= cfg_data_i;
        RegCoefWord3:   coef_q[24]    <= cfg_data_i[CoefW-1:0];
        default: ;
      endcase
    end
  end

  c2d_front #(
    .MaxWidth(MaxWidth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .width_i    (width_q),
    .height_i   (height_q),
    .pixel_i    (pixel_in_i),
    .valid_i    (in_valid_i),
    .ready_o    (in_ready_o),
    .win_valid_o(win_valid),
    .win_o      (win),
    .win_ready_i(win_ready)
  );

  c2d_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .win_valid_i (win_valid),
    .win_i       (win),
    .win_ready_o (win_ready),
    .coef_i      (coef_q),
    .pixel_o     (pixel_out_o),
    .frame_last_o(frame_last_o),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i)
  );

endmodule
